@@ src/ybr_pkg.sv @@
// ybr_pkg: shared types, codes and constants of the ymodem block receiver
// no dependencies; used by the interfaces and all modules of the block

package ybr_pkg;

    localparam int SHORT_BLOCK_BYTES = 128;
    localparam int OFF_W             = 10;

    localparam logic [7:0]  BYTE_SOH   = 8'h01;
    localparam logic [7:0]  BYTE_STX   = 8'h02;
    localparam logic [7:0]  BYTE_ABORT = 8'h03;
    localparam logic [7:0]  BYTE_EOT   = 8'h04;
    localparam logic [7:0]  BYTE_CAN   = 8'h18;
    localparam logic [7:0]  SEQ_INIT   = 8'h00;
    localparam logic [7:0]  COMPL_INIT = 8'hff;
    localparam logic [15:0] CRC_POLY   = 16'h1021;
    localparam logic [15:0] CRC_INIT   = 16'h0000;

    typedef enum logic [6:0] {
        PH_IDLE   = 7'b0000001,
        PH_HEADER = 7'b0000010,
        PH_SEQ    = 7'b0000100,
        PH_COMPL  = 7'b0001000,
        PH_DATA   = 7'b0010000,
        PH_CRC_HI = 7'b0100000,
        PH_CRC_LO = 7'b1000000
    } t_phase;

    typedef enum logic [3:0] {
        EV_PAYLOAD    = 4'd0,
        EV_OK         = 4'd1,
        EV_EOT        = 4'd2,
        EV_DONE       = 4'd3,
        EV_BAD_SEQ    = 4'd4,
        EV_BAD_COMPL  = 4'd5,
        EV_CRC_ERR    = 4'd6,
        EV_TIMEOUT    = 4'd7,
        EV_CANCEL     = 4'd8,
        EV_USER_ABORT = 4'd9
    } t_event;

    typedef enum logic [1:0] {
        RP_NONE  = 2'd0,
        RP_ACK   = 2'd1,
        RP_ACK_C = 2'd2,
        RP_ABORT = 2'd3
    } t_reply;

    typedef enum logic {
        ACT_BYTE    = 1'b0,
        ACT_TIMEOUT = 1'b1
    } t_action;

endpackage

@@ src/ybr_in_if.sv @@
// ybr_in_if: valid/ready channel carrying one received byte or timeout
// depends on ybr_pkg

interface ybr_in_if;
    logic             valid;
    logic             ready;
    ybr_pkg::t_action action;
    logic [7:0]       rx_byte;

    modport source (output valid, output action, output rx_byte, input ready);
    modport sink   (input valid, input action, input rx_byte, output ready);
endinterface

@@ src/ybr_out_if.sv @@
// ybr_out_if: valid/ready channel carrying one receiver result
// depends on ybr_pkg

interface ybr_out_if;
    logic                        valid;
    logic                        ready;
    ybr_pkg::t_event             event_res;
    logic [7:0]                  payload_byte;
    logic [ybr_pkg::OFF_W-1:0]   byte_offset;
    logic                        info_block;
    ybr_pkg::t_reply             reply;

    modport source (output valid, output event_res, output payload_byte,
                    output byte_offset, output info_block, output reply, input ready);
    modport sink   (input valid, input event_res, input payload_byte,
                    input byte_offset, input info_block, input reply, output ready);
endinterface

@@ src/ybr_crc16.sv @@
// ybr_crc16: one-byte update of the crc-16/xmodem remainder, msb first
// depends on ybr_pkg

module ybr_crc16 (
    input  logic [15:0] i_crc,
    input  logic [7:0]  i_data,
    output logic [15:0] o_crc
);
    import ybr_pkg::*;

    always_comb begin
        logic [15:0] c;
        c = i_crc ^ {i_data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        o_crc = c;
    end
endmodule

@@ src/ymodem_block_receiver_core.sv @@
// ymodem_block_receiver_core: deframes ymodem blocks with crc-16, one byte per transaction
// throughput: one input transaction per cycle while the result side keeps up
// set by the single input register and the single result register
// reset: synchronous active-low i_rst_n; returns to idle waiting for the first soh
// depends on ybr_pkg, ybr_in_if, ybr_out_if, ybr_crc16

module ymodem_block_receiver_core #(
    parameter int LONG_BLOCK_BYTES = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ybr_in_if.sink     i_in,
    ybr_out_if.source  o_out
);
    import ybr_pkg::*;

    localparam int CNT_W = $clog2(LONG_BLOCK_BYTES + 1);
    localparam logic [CNT_W-1:0] LEN_SHORT = CNT_W'(SHORT_BLOCK_BYTES);
    localparam logic [CNT_W-1:0] LEN_LONG  = CNT_W'(LONG_BLOCK_BYTES);

    // input register
    logic       r_s1_valid;
    t_action    r_s1_action;
    logic [7:0] r_s1_byte;

    // receiver state
    t_phase           r_phase,       n_phase;
    logic [7:0]       r_exp_seq,     n_exp_seq;
    logic [7:0]       r_exp_compl,   n_exp_compl;
    logic [CNT_W-1:0] r_byte_count,  n_byte_count;
    logic [CNT_W-1:0] r_block_len,   n_block_len;
    logic [15:0]      r_crc,         n_crc;
    logic [7:0]       r_crc_hi,      n_crc_hi;
    logic             r_end_seen,    n_end_seen;
    logic             r_first_block, n_first_block;

    // result register
    logic             r_out_valid;
    t_event           r_out_event;
    logic [7:0]       r_out_data;
    logic [OFF_W-1:0] r_out_off;
    logic             r_out_info;
    t_reply           r_out_reply;

    logic             s1_fire;
    logic             res_valid;
    t_event           res_event;
    logic [7:0]       res_data;
    logic [OFF_W-1:0] res_off;
    logic             res_info;
    t_reply           res_reply;
    logic             do_clear;
    logic [15:0]      crc_next;
    logic [CNT_W-1:0] count_inc;

    assign s1_fire    = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || s1_fire;
    assign count_inc  = r_byte_count + CNT_W'(1);

    ybr_crc16 u_crc (
        .i_crc  (r_crc),
        .i_data (r_s1_byte),
        .o_crc  (crc_next)
    );

    always_comb begin
        n_phase       = r_phase;
        n_exp_seq     = r_exp_seq;
        n_exp_compl   = r_exp_compl;
        n_byte_count  = r_byte_count;
        n_block_len   = r_block_len;
        n_crc         = r_crc;
        n_crc_hi      = r_crc_hi;
        n_end_seen    = r_end_seen;
        n_first_block = r_first_block;
        res_valid     = 1'b0;
        res_event     = EV_PAYLOAD;
        res_data      = 8'h00;
        res_off       = '0;
        res_info      = r_first_block | r_end_seen;
        res_reply     = RP_NONE;
        do_clear      = 1'b0;

        if (r_phase == PH_IDLE) begin
            if (r_s1_action == ACT_BYTE) begin
                if (r_s1_byte == BYTE_ABORT) begin
                    do_clear  = 1'b1;
                    res_valid = 1'b1;
                    res_event = EV_USER_ABORT;
                    res_info  = 1'b0;
                end else if (r_s1_byte == BYTE_SOH) begin
                    n_exp_seq     = SEQ_INIT;
                    n_exp_compl   = COMPL_INIT;
                    n_first_block = 1'b1;
                    n_end_seen    = 1'b0;
                    n_block_len   = LEN_SHORT;
                    n_byte_count  = '0;
                    n_crc         = CRC_INIT;
                    n_phase       = PH_SEQ;
                end
            end
        end else if (r_s1_action == ACT_TIMEOUT) begin
            do_clear  = 1'b1;
            res_valid = 1'b1;
            res_event = EV_TIMEOUT;
            res_reply = RP_ABORT;
        end else begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_s1_byte == BYTE_CAN) begin
                        do_clear  = 1'b1;
                        res_valid = 1'b1;
                        res_event = EV_CANCEL;
                        res_reply = RP_ABORT;
                    end else if (r_s1_byte == BYTE_EOT) begin
                        n_end_seen  = 1'b1;
                        n_exp_seq   = SEQ_INIT;
                        n_exp_compl = COMPL_INIT;
                        res_valid   = 1'b1;
                        res_event   = EV_EOT;
                        res_reply   = RP_ACK_C;
                    end else begin
                        if (r_s1_byte == BYTE_SOH) begin
                            n_block_len = LEN_SHORT;
                        end else if (r_s1_byte == BYTE_STX) begin
                            n_block_len = LEN_LONG;
                        end else begin
                            n_block_len = '0;
                        end
                        n_byte_count = '0;
                        n_crc        = CRC_INIT;
                        n_phase      = PH_SEQ;
                    end
                end
                PH_SEQ: begin
                    if (r_s1_byte != r_exp_seq) begin
                        do_clear  = 1'b1;
                        res_valid = 1'b1;
                        res_event = EV_BAD_SEQ;
                        res_reply = RP_ABORT;
                    end else begin
                        n_phase = PH_COMPL;
                    end
                end
                PH_COMPL: begin
                    if (r_s1_byte != r_exp_compl) begin
                        do_clear  = 1'b1;
                        res_valid = 1'b1;
                        res_event = EV_BAD_COMPL;
                        res_reply = RP_ABORT;
                    end else if (r_block_len == '0) begin
                        n_phase = PH_CRC_HI;
                    end else begin
                        n_phase = PH_DATA;
                    end
                end
                PH_DATA: begin
                    n_crc        = crc_next;
                    n_byte_count = count_inc;
                    if (count_inc >= r_block_len) begin
                        n_phase = PH_CRC_HI;
                    end
                    res_valid = 1'b1;
                    res_event = EV_PAYLOAD;
                    res_data  = r_s1_byte;
                    res_off   = OFF_W'(r_byte_count);
                end
                PH_CRC_HI: begin
                    n_crc_hi = r_s1_byte;
                    n_phase  = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    res_valid = 1'b1;
                    if (r_crc_hi != r_crc[15:8] || r_s1_byte != r_crc[7:0]) begin
                        do_clear  = 1'b1;
                        res_event = EV_CRC_ERR;
                        res_reply = RP_ABORT;
                    end else if (r_end_seen) begin
                        do_clear  = 1'b1;
                        res_event = EV_DONE;
                        res_reply = RP_ACK;
                    end else begin
                        n_exp_seq     = r_exp_seq + 8'd1;
                        n_exp_compl   = r_exp_compl - 8'd1;
                        n_phase       = PH_HEADER;
                        n_first_block = 1'b0;
                        res_event     = EV_OK;
                        res_reply     = r_first_block ? RP_ACK_C : RP_ACK;
                    end
                end
                default: begin
                    do_clear = 1'b1;
                end
            endcase
        end

        if (do_clear) begin
            n_phase       = PH_IDLE;
            n_exp_seq     = SEQ_INIT;
            n_exp_compl   = COMPL_INIT;
            n_byte_count  = '0;
            n_block_len   = '0;
            n_crc         = CRC_INIT;
            n_crc_hi      = 8'h00;
            n_end_seen    = 1'b0;
            n_first_block = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_phase       <= PH_IDLE;
            r_exp_seq     <= SEQ_INIT;
            r_exp_compl   <= COMPL_INIT;
            r_byte_count  <= '0;
            r_block_len   <= '0;
            r_crc         <= CRC_INIT;
            r_crc_hi      <= 8'h00;
            r_end_seen    <= 1'b0;
            r_first_block <= 1'b1;
        end else begin
            if (i_in.ready) begin
                r_s1_valid <= i_in.valid;
            end
            if (s1_fire) begin
                r_phase       <= n_phase;
                r_exp_seq     <= n_exp_seq;
                r_exp_compl   <= n_exp_compl;
                r_byte_count  <= n_byte_count;
                r_block_len   <= n_block_len;
                r_crc         <= n_crc;
                r_crc_hi      <= n_crc_hi;
                r_end_seen    <= n_end_seen;
                r_first_block <= n_first_block;
                r_out_valid   <= res_valid;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_action <= i_in.action;
            r_s1_byte   <= i_in.rx_byte;
        end
        if (s1_fire && res_valid) begin
            r_out_event <= res_event;
            r_out_data  <= res_data;
            r_out_off   <= res_off;
            r_out_info  <= res_info;
            r_out_reply <= res_reply;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.event_res    = r_out_event;
    assign o_out.payload_byte = r_out_data;
    assign o_out.byte_offset  = r_out_off;
    assign o_out.info_block   = r_out_info;
    assign o_out.reply        = r_out_reply;

    // payload count never reaches the block length while still in the data phase
    a_count_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_DATA) |-> (r_byte_count < r_block_len))
        else $error("byte count out of range in data phase");

    // a result is never overwritten before it is taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !o_out.ready) |-> !s1_fire)
        else $error("pending result overwritten");

    // every abort-type verdict returns the receiver to idle with block 0 expected
    a_abort_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s1_fire && res_valid && res_reply == RP_ABORT)
        |=> (r_phase == PH_IDLE && r_first_block && !r_end_seen))
        else $error("abort did not return to idle");

    // payload results never request a reply
    a_payload_no_reply: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_event == EV_PAYLOAD) |-> (r_out_reply == RP_NONE))
        else $error("payload result carries a reply");

endmodule

@@ dv/tb_ymodem_block_receiver_core.sv @@
// tb_ymodem_block_receiver_core: self-checking testbench for the ymodem block receiver core
// drives byte and timeout transactions, predicts deframing events and checks every result
// depends on ybr_pkg, ybr_in_if, ybr_out_if and ymodem_block_receiver_core
`timescale 1ns / 1ps

module tb_ymodem_block_receiver_core;
    import ybr_pkg::*;

    localparam int LONG_BLOCK    = 1024;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int HOLD_CYCLES   = 300;
    localparam int TAIL_CYCLES   = 16;
    localparam int PHASE_ITEMS   = 100;

    typedef struct packed {
        t_action    action;
        logic [7:0] rx_byte;
    } rx_item_t;

    typedef struct packed {
        t_event     event_res;
        logic [7:0] payload_byte;
        logic [9:0] byte_offset;
        logic       info_block;
        t_reply     reply;
    } rx_event_t;

    typedef enum int {
        FLT_NONE,
        FLT_SEQ,
        FLT_COMPL,
        FLT_CRC_HI,
        FLT_CRC_LO,
        FLT_TIMEOUT,
        FLT_CANCEL,
        FLT_HDR_TIMEOUT
    } t_fault;

    logic i_clk = 1'b0;
    logic i_rst_n;

    ybr_in_if  rx_if();
    ybr_out_if res_if();

    ymodem_block_receiver_core #(
        .LONG_BLOCK_BYTES(LONG_BLOCK)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (rx_if),
        .o_out  (res_if)
    );

    rx_item_t  line_items[$];
    rx_event_t expected_events[$];

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int queued_count   = 0;
    int fail_count     = 0;
    int cycle_count    = 0;
    int hold_left      = 0;
    bit hold_armed     = 1'b0;
    bit hold_done      = 1'b0;
    bit rx_taken       = 1'b0;

    // receiver state as the predictor sees it
    t_phase      rcv_phase;
    logic [7:0]  rcv_seq;
    logic [7:0]  rcv_compl;
    logic [10:0] rcv_count;
    logic [10:0] rcv_len;
    logic [15:0] rcv_crc;
    logic [7:0]  rcv_crc_hi;
    logic        rcv_end_seen;
    logic        rcv_first;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    function automatic logic [15:0] crc16_xmodem_byte(logic [15:0] crc, logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int i = 0; i < 8; i++)
            c = c[15] ? ((c << 1) ^ CRC_POLY) : (c << 1);
        return c;
    endfunction

    task automatic reset_receiver();
        rcv_phase    = PH_IDLE;
        rcv_seq      = SEQ_INIT;
        rcv_compl    = COMPL_INIT;
        rcv_count    = '0;
        rcv_len      = '0;
        rcv_crc      = CRC_INIT;
        rcv_crc_hi   = '0;
        rcv_end_seen = 1'b0;
        rcv_first    = 1'b1;
    endtask

    task automatic open_block(int len);
        rcv_len   = 11'(len);
        rcv_count = '0;
        rcv_crc   = CRC_INIT;
        rcv_phase = PH_SEQ;
    endtask

    task automatic note_event(t_event ev, logic [7:0] data, logic [9:0] off, logic info,
                              t_reply rep);
        expected_events.push_back('{event_res: ev, payload_byte: data, byte_offset: off,
                                    info_block: info, reply: rep});
    endtask

    task automatic deframe_step(t_action act, logic [7:0] b);
        logic       info;
        logic [9:0] off;
        info = rcv_first || rcv_end_seen;
        if (rcv_phase == PH_IDLE) begin
            if (act == ACT_BYTE && b == BYTE_ABORT) begin
                reset_receiver();
                note_event(EV_USER_ABORT, 8'h00, '0, 1'b0, RP_NONE);
            end else if (act == ACT_BYTE && b == BYTE_SOH) begin
                rcv_seq      = SEQ_INIT;
                rcv_compl    = COMPL_INIT;
                rcv_first    = 1'b1;
                rcv_end_seen = 1'b0;
                open_block(SHORT_BLOCK_BYTES);
            end
        end else if (act == ACT_TIMEOUT) begin
            reset_receiver();
            note_event(EV_TIMEOUT, 8'h00, '0, info, RP_ABORT);
        end else begin
            case (rcv_phase)
                PH_HEADER: begin
                    if (b == BYTE_CAN) begin
                        reset_receiver();
                        note_event(EV_CANCEL, 8'h00, '0, info, RP_ABORT);
                    end else if (b == BYTE_EOT) begin
                        rcv_end_seen = 1'b1;
                        rcv_seq      = SEQ_INIT;
                        rcv_compl    = COMPL_INIT;
                        note_event(EV_EOT, 8'h00, '0, info, RP_ACK_C);
                    end else if (b == BYTE_SOH) begin
                        open_block(SHORT_BLOCK_BYTES);
                    end else if (b == BYTE_STX) begin
                        open_block(LONG_BLOCK);
                    end else begin
                        open_block(0);
                    end
                end
                PH_SEQ: begin
                    if (b != rcv_seq) begin
                        reset_receiver();
                        note_event(EV_BAD_SEQ, 8'h00, '0, info, RP_ABORT);
                    end else begin
                        rcv_phase = PH_COMPL;
                    end
                end
                PH_COMPL: begin
                    if (b != rcv_compl) begin
                        reset_receiver();
                        note_event(EV_BAD_COMPL, 8'h00, '0, info, RP_ABORT);
                    end else begin
                        rcv_phase = (rcv_len == 0) ? PH_CRC_HI : PH_DATA;
                    end
                end
                PH_DATA: begin
                    off       = rcv_count[9:0];
                    rcv_crc   = crc16_xmodem_byte(rcv_crc, b);
                    rcv_count = rcv_count + 11'd1;
                    if (rcv_count >= rcv_len)
                        rcv_phase = PH_CRC_HI;
                    note_event(EV_PAYLOAD, b, off, info, RP_NONE);
                end
                PH_CRC_HI: begin
                    rcv_crc_hi = b;
                    rcv_phase  = PH_CRC_LO;
                end
                PH_CRC_LO: begin
                    if (rcv_crc_hi != rcv_crc[15:8] || b != rcv_crc[7:0]) begin
                        reset_receiver();
                        note_event(EV_CRC_ERR, 8'h00, '0, info, RP_ABORT);
                    end else if (rcv_end_seen) begin
                        reset_receiver();
                        note_event(EV_DONE, 8'h00, '0, info, RP_ACK);
                    end else begin
                        rcv_seq   = rcv_seq + 8'd1;
                        rcv_compl = rcv_compl - 8'd1;
                        rcv_phase = PH_HEADER;
                        if (rcv_first) begin
                            rcv_first = 1'b0;
                            note_event(EV_OK, 8'h00, '0, info, RP_ACK_C);
                        end else begin
                            note_event(EV_OK, 8'h00, '0, info, RP_ACK);
                        end
                    end
                end
                default: reset_receiver();
            endcase
        end
    endtask

    // stimulus building

    task automatic queue_item(t_action act, logic [7:0] b);
        line_items.push_back('{action: act, rx_byte: b});
        queued_count++;
    endtask

    function automatic logic [7:0] empty_header();
        logic [7:0] b;
        b = 8'($urandom_range(255));
        if (b == BYTE_SOH || b == BYTE_STX || b == BYTE_EOT || b == BYTE_CAN)
            b = BYTE_ABORT;
        return b;
    endfunction

    task automatic queue_block(bit has_hdr, logic [7:0] hdr, int len, logic [7:0] seq,
                               t_fault fault);
        logic [7:0]  frame[$];
        logic [7:0]  b;
        logic [15:0] crc;
        int          cut;
        int          i;
        crc = CRC_INIT;
        if (has_hdr) begin
            if (fault == FLT_CANCEL) begin
                queue_item(ACT_BYTE, BYTE_CAN);
                return;
            end
            if (fault == FLT_HDR_TIMEOUT) begin
                queue_item(ACT_TIMEOUT, 8'($urandom_range(255)));
                return;
            end
            queue_item(ACT_BYTE, hdr);
        end
        frame.push_back(seq);
        frame.push_back(~seq);
        for (i = 0; i < len; i++) begin
            b   = 8'($urandom_range(255));
            crc = crc16_xmodem_byte(crc, b);
            frame.push_back(b);
        end
        frame.push_back(crc[15:8]);
        frame.push_back(crc[7:0]);
        cut = frame.size();
        case (fault)
            FLT_SEQ:     frame[0]       = frame[0] ^ 8'($urandom_range(1, 255));
            FLT_COMPL:   frame[1]       = frame[1] ^ 8'($urandom_range(1, 255));
            FLT_CRC_HI:  frame[len + 2] = frame[len + 2] ^ 8'($urandom_range(1, 255));
            FLT_CRC_LO:  frame[len + 3] = frame[len + 3] ^ 8'($urandom_range(1, 255));
            FLT_TIMEOUT: cut            = $urandom_range(frame.size() - 1);
            default: ;
        endcase
        for (i = 0; i < cut; i++)
            queue_item(ACT_BYTE, frame[i]);
        if (fault == FLT_TIMEOUT)
            queue_item(ACT_TIMEOUT, 8'($urandom_range(255)));
    endtask

    task automatic queue_session(int data_blocks, bit long_first, bit broken);
        int         fault_at;
        int         k;
        int         len;
        logic [7:0] hdr;
        logic [7:0] seq;
        logic [7:0] b;
        t_fault     fault;
        // line noise while idle
        repeat ($urandom_range(0, 3)) begin
            b = 8'($urandom_range(255));
            if (b == BYTE_SOH || b == BYTE_ABORT)
                b = 8'h55;
            if ($urandom_range(1) == 1)
                queue_item(ACT_TIMEOUT, b);
            else
                queue_item(ACT_BYTE, b);
        end
        if ($urandom_range(5) == 0)
            queue_item(ACT_BYTE, BYTE_ABORT);
        fault_at = broken ? $urandom_range(data_blocks + 1) : -1;
        fault = (fault_at == 0) ? t_fault'($urandom_range(FLT_SEQ, FLT_TIMEOUT)) : FLT_NONE;
        queue_item(ACT_BYTE, BYTE_SOH);
        queue_block(1'b0, BYTE_SOH, SHORT_BLOCK_BYTES, SEQ_INIT, fault);
        if (fault != FLT_NONE)
            return;
        seq = SEQ_INIT + 8'd1;
        for (k = 1; k <= data_blocks; k++) begin
            fault = (k == fault_at) ? t_fault'($urandom_range(FLT_SEQ, FLT_HDR_TIMEOUT))
                                    : FLT_NONE;
            if (long_first && k == 1) begin
                hdr = BYTE_STX;
                len = LONG_BLOCK;
            end else if ($urandom_range(99) < 55) begin
                hdr = empty_header();
                len = 0;
            end else begin
                hdr = BYTE_SOH;
                len = SHORT_BLOCK_BYTES;
            end
            queue_block(1'b1, hdr, len, seq, fault);
            if (fault != FLT_NONE)
                return;
            seq = seq + 8'd1;
        end
        queue_item(ACT_BYTE, BYTE_EOT);
        if ($urandom_range(2) == 0)
            queue_item(ACT_BYTE, BYTE_EOT);
        fault = (fault_at == data_blocks + 1)
              ? t_fault'($urandom_range(FLT_SEQ, FLT_HDR_TIMEOUT)) : FLT_NONE;
        // null block closes the transfer
        if ($urandom_range(99) < 70)
            queue_block(1'b1, empty_header(), 0, SEQ_INIT, fault);
        else
            queue_block(1'b1, BYTE_SOH, SHORT_BLOCK_BYTES, SEQ_INIT, fault);
    endtask

    task automatic wait_drained();
        while (line_items.size() != 0 || rx_if.valid || expected_events.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic run_phase(int send_pct, int recv_pct);
        int  start_count;
        bit  first;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        start_count    = queued_count;
        first          = 1'b1;
        while (queued_count - start_count < PHASE_ITEMS) begin
            queue_session($urandom_range(0, 1), 1'b0, first ? 1'b0 : ($urandom_range(2) == 0));
            first = 1'b0;
        end
        wait_drained();
    endtask

    // byte source and result-side ready
    always @(negedge i_clk) begin : drive_line
        rx_item_t next_item;
        if (!rx_if.valid || rx_taken) begin
            if (i_rst_n && line_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                next_item      = line_items.pop_front();
                rx_if.valid    = 1'b1;
                rx_if.action   = next_item.action;
                rx_if.rx_byte  = next_item.rx_byte;
            end else begin
                rx_if.valid    = 1'b0;
                rx_if.action   = t_action'($urandom_range(1));
                rx_if.rx_byte  = 8'($urandom_range(255));
            end
        end
        res_if.ready = (hold_left == 0) && ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        rx_taken = i_rst_n && rx_if.valid && rx_if.ready;
        if (rx_taken)
            deframe_step(rx_if.action, rx_if.rx_byte);
    end

    // long result hold-off so the core backs up into its input
    always @(posedge i_clk) begin
        if (hold_armed && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
        end else if (hold_left > 0) begin
            hold_left = hold_left - 1;
        end
    end

    always @(posedge i_clk) begin : check_events
        rx_event_t want;
        if (i_rst_n && res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
            if (expected_events.size() == 0) begin
                $error("unexpected transaction: event_res %0d", res_if.event_res);
                fail_count++;
            end else begin
                want = expected_events.pop_front();
                if (res_if.event_res !== want.event_res) begin
                    $error("event_res: expected %0d, got %0d", want.event_res,
                           res_if.event_res);
                    fail_count++;
                end
                if (res_if.payload_byte !== want.payload_byte) begin
                    $error("payload_byte: expected %0d, got %0d", want.payload_byte,
                           res_if.payload_byte);
                    fail_count++;
                end
                if (res_if.byte_offset !== want.byte_offset) begin
                    $error("byte_offset: expected %0d, got %0d", want.byte_offset,
                           res_if.byte_offset);
                    fail_count++;
                end
                if (res_if.info_block !== want.info_block) begin
                    $error("info_block: expected %0d, got %0d", want.info_block,
                           res_if.info_block);
                    fail_count++;
                end
                if (res_if.reply !== want.reply) begin
                    $error("reply: expected %0d, got %0d", want.reply, res_if.reply);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n        = 1'b0;
        rx_if.valid    = 1'b0;
        rx_if.action   = ACT_BYTE;
        rx_if.rx_byte  = 8'h00;
        res_if.ready   = 1'b0;
        reset_receiver();
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // idle: ignored bytes and timeout, then user abort
        queue_item(ACT_TIMEOUT, 8'hff);
        queue_item(ACT_BYTE, 8'h00);
        queue_item(ACT_BYTE, 8'hff);
        queue_item(ACT_BYTE, BYTE_STX);
        queue_item(ACT_BYTE, BYTE_EOT);
        queue_item(ACT_BYTE, BYTE_CAN);
        queue_item(ACT_BYTE, BYTE_ABORT);
        // first block broken at each early step
        queue_item(ACT_BYTE, BYTE_SOH);
        queue_item(ACT_TIMEOUT, 8'h00);
        queue_item(ACT_BYTE, BYTE_SOH);
        queue_item(ACT_BYTE, 8'h01);
        queue_item(ACT_BYTE, BYTE_SOH);
        queue_item(ACT_BYTE, 8'hff);
        queue_item(ACT_BYTE, BYTE_SOH);
        queue_item(ACT_BYTE, SEQ_INIT);
        queue_item(ACT_BYTE, 8'h00);
        queue_item(ACT_BYTE, BYTE_SOH);
        queue_item(ACT_BYTE, SEQ_INIT);
        queue_item(ACT_BYTE, COMPL_INIT);
        queue_item(ACT_TIMEOUT, 8'h00);
        wait_drained();

        run_phase(0, 0);
        run_phase(86, 0);
        run_phase(0, 86);
        run_phase(19, 19);

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        queue_session(1, 1'b1, 1'b0);
        hold_armed = 1'b1;
        wait_drained();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ ymodem_block_receiver_core.f @@
src/ybr_pkg.sv
src/ybr_in_if.sv
src/ybr_out_if.sv
src/ybr_crc16.sv
src/ymodem_block_receiver_core.sv
dv/tb_ymodem_block_receiver_core.sv
